>>> hdl/ppaq_pkg.sv
// ppaq_pkg: item codes, status codes and area limits shared by the polygon query block
// and its port checker
// no dependencies
`default_nettype none

package ppaq_pkg;

    // item kind carried on tuser
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_TEST   = 2'd2,
        MODE_AREA   = 2'd3
    } mode_t;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // doubled area result width and its saturation value
    localparam int unsigned AREA_W = 38;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

endpackage

`default_nettype wire

>>> hdl/ppaq_ram.sv
// ppaq_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module ppaq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/polygon_point_and_area_query.sv
// polygon_point_and_area_query: polygon vertex store with even-odd point test,
// doubled shoelace area and bounding box; uses ppaq_pkg and ppaq_ram

// Keeps one closed polygon of up to MAX_VERTICES signed vertices in a vertex memory.
// Each input item clears the polygon, appends a vertex, tests a point by the even-odd
// crossing rule (exact, by cross-multiplication) or asks for twice the absolute area
// and the bounding box; every item gives exactly one result item. A point test or area
// query on n stored vertices walks the vertex memory, one vertex read per cycle (n + 1
// reads, last vertex first), followed by a drain of the read, operand, multiply and
// accumulate pipeline, an absolute-value step and the result load. One item is in work
// at a time; the next item is taken while a finished result still waits on the output.
// An append to a full store is dropped and flagged in status; the area saturates at
// 2^38 - 1.
`default_nettype none

module polygon_point_and_area_query #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // input items
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // px, py
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // mode
    input  wire logic [1:0]                           s_tuser,
    // result items
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // inside_res, double_area, min_x, min_y, max_x, max_y, vertex_count, status
    output logic [((ppaq_pkg::AREA_W + 4*COORD_BITS + $clog2(MAX_VERTICES+1) + 2 + 7)
                   / 8)*8-1:0]                        m_tdata
);

    localparam int C      = COORD_BITS;
    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W = C + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + $clog2(MAX_VERTICES) + 1;
    localparam int AREA_W = ppaq_pkg::AREA_W;
    localparam int WIDE_W = (SUM_W > AREA_W) ? SUM_W : AREA_W;
    localparam int OUT_RAW = AREA_W + 4*C + CNT_W + 2;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_ABS   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    ppaq_pkg::mode_t mode_reg;
    logic signed [C-1:0] q_x_reg, q_y_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic status_reg;

    logic in_fire;
    ppaq_pkg::mode_t in_mode;
    logic signed [C-1:0] in_px, in_py;

    // vertex memory ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [2*C-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [2*C-1:0] ram_rdata;

    // pipeline
    logic rd_valid_reg, rd_first_reg;
    logic op_valid_reg, prod_valid_reg;
    logic signed [C-1:0] prev_x_reg, prev_y_reg;
    logic signed [C-1:0] cur_x, cur_y;
    logic signed [DIFF_W-1:0] a0_reg, b0_reg, a1_reg, b1_reg;
    logic signed [DIFF_W-1:0] a0_next, b0_next, a1_next, b1_next;
    logic cond_next, dypos_next;
    logic cond_reg, dypos_reg, cond2_reg, dypos2_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic signed [PROD_W:0] term;
    logic signed [SUM_W-1:0] sum_reg;
    logic odd_reg;
    logic [SUM_W-1:0] area_abs_reg;
    logic [WIDE_W-1:0] area_wide;
    logic [AREA_W-1:0] area_sat;

    // bounding box
    logic box_init_reg;
    logic signed [C-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;

    // result register
    logic out_valid_reg;
    logic out_load;
    logic out_inside_reg;
    logic [AREA_W-1:0] out_area_reg;
    logic signed [C-1:0] out_min_x_reg, out_min_y_reg, out_max_x_reg, out_max_y_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic out_status_reg;

    // input unpacking
    assign in_px    = s_tdata[C-1:0];
    assign in_py    = s_tdata[2*C-1:C];
    assign in_mode  = ppaq_pkg::mode_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // vertex memory, y in the upper half
    assign ram_we    = in_fire && (in_mode == ppaq_pkg::MODE_APPEND)
                       && (count_reg < CNT_W'(MAX_VERTICES));
    assign ram_waddr = AW'(count_reg);
    assign ram_wdata = {in_py, in_px};
    assign ram_re    = (state_reg == ST_WALK);
    assign ram_raddr = (rd_cnt_reg == '0) ? AW'(count_reg - CNT_W'(1))
                                          : AW'(rd_cnt_reg - CNT_W'(1));

    ppaq_ram #(
        .WIDTH (2*C),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_mode == ppaq_pkg::MODE_CLEAR || in_mode == ppaq_pkg::MODE_APPEND)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_ABS;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (rd_cnt_reg == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !op_valid_reg && !prod_valid_reg)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_cnt_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            op_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= ram_re;
            rd_first_reg   <= (rd_cnt_reg == '0);
            op_valid_reg   <= rd_valid_reg && !rd_first_reg;
            prod_valid_reg <= op_valid_reg;
            if (in_fire)
            begin
                rd_cnt_reg <= '0;
                if (in_mode == ppaq_pkg::MODE_CLEAR)
                begin
                    count_reg <= '0;
                end
                else if (ram_we)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else if (ram_re)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg   <= in_mode;
            q_x_reg    <= in_px;
            q_y_reg    <= in_py;
            status_reg <= (in_mode == ppaq_pkg::MODE_APPEND && !ram_we)
                          ? ppaq_pkg::STATUS_FULL : ppaq_pkg::STATUS_OK;
        end
    end

    assign cur_x = ram_rdata[C-1:0];
    assign cur_y = ram_rdata[2*C-1:C];

    // edge operands: current vertex i, previous vertex j
    always_comb
    begin
        if (mode_reg == ppaq_pkg::MODE_TEST)
        begin
            a0_next = DIFF_W'(q_y_reg) - DIFF_W'(cur_y);
            b0_next = DIFF_W'(prev_x_reg) - DIFF_W'(cur_x);
            a1_next = DIFF_W'(q_x_reg) - DIFF_W'(cur_x);
            b1_next = DIFF_W'(prev_y_reg) - DIFF_W'(cur_y);
        end
        else
        begin
            a0_next = DIFF_W'(prev_x_reg);
            b0_next = DIFF_W'(cur_y);
            a1_next = DIFF_W'(prev_y_reg);
            b1_next = DIFF_W'(cur_x);
        end
        cond_next  = (cur_y < q_y_reg && prev_y_reg >= q_y_reg)
                     || (prev_y_reg < q_y_reg && cur_y >= q_y_reg);
        dypos_next = (prev_y_reg > cur_y);
    end

    // operand and product stages
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
            a0_reg     <= a0_next;
            b0_reg     <= b0_next;
            a1_reg     <= a1_next;
            b1_reg     <= b1_next;
            cond_reg   <= cond_next;
            dypos_reg  <= dypos_next;
        end
        p0_reg     <= a0_reg * b0_reg;
        p1_reg     <= a1_reg * b1_reg;
        cond2_reg  <= cond_reg;
        dypos2_reg <= dypos_reg;
    end

    assign term = PROD_W'(p0_reg) - PROD_W'(p1_reg) + (PROD_W+1)'(0);

    // crossing parity, area sum and bounding box
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            odd_reg      <= 1'b0;
            sum_reg      <= '0;
            box_init_reg <= 1'b0;
            min_x_reg    <= '0;
            min_y_reg    <= '0;
            max_x_reg    <= '0;
            max_y_reg    <= '0;
        end
        else
        begin
            if (prod_valid_reg)
            begin
                if (cond2_reg && (dypos2_reg ? (p0_reg < p1_reg) : (p1_reg < p0_reg)))
                begin
                    odd_reg <= !odd_reg;
                end
                sum_reg <= sum_reg + SUM_W'(term);
            end
            if (rd_valid_reg)
            begin
                box_init_reg <= 1'b1;
                if (!box_init_reg || cur_x < min_x_reg) min_x_reg <= cur_x;
                if (!box_init_reg || cur_y < min_y_reg) min_y_reg <= cur_y;
                if (!box_init_reg || cur_x > max_x_reg) max_x_reg <= cur_x;
                if (!box_init_reg || cur_y > max_y_reg) max_y_reg <= cur_y;
            end
        end
        if (state_reg == ST_ABS)
        begin
            area_abs_reg <= sum_reg[SUM_W-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
        end
    end

    // area saturation
    always_comb
    begin
        area_wide = WIDE_W'(area_abs_reg);
        area_sat  = (area_wide > WIDE_W'(ppaq_pkg::AREA_MAX)) ? ppaq_pkg::AREA_MAX
                                                               : area_wide[AREA_W-1:0];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_inside_reg <= (mode_reg == ppaq_pkg::MODE_TEST) && odd_reg;
            out_count_reg  <= count_reg;
            out_status_reg <= status_reg;
            if (mode_reg == ppaq_pkg::MODE_AREA)
            begin
                out_area_reg  <= area_sat;
                out_min_x_reg <= min_x_reg;
                out_min_y_reg <= min_y_reg;
                out_max_x_reg <= max_x_reg;
                out_max_y_reg <= max_y_reg;
            end
            else
            begin
                out_area_reg  <= '0;
                out_min_x_reg <= '0;
                out_min_y_reg <= '0;
                out_max_x_reg <= '0;
                out_max_y_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_status_reg, out_count_reg, out_max_y_reg, out_max_x_reg,
                              out_min_y_reg, out_min_x_reg, out_area_reg, out_inside_reg});

endmodule

`default_nettype wire

>>> hdl/ppaq_checker.sv
// ppaq_checker: port-level assertions for polygon_point_and_area_query, bound to the top
// level; uses ppaq_pkg
`default_nettype none

module ppaq_checker #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input wire logic [1:0] s_tuser,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((ppaq_pkg::AREA_W + 4*COORD_BITS + $clog2(MAX_VERTICES+1) + 2 + 7)
                       / 8)*8-1:0] m_tdata
);

    localparam int C      = COORD_BITS;
    localparam int AREA_W = ppaq_pkg::AREA_W;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int MINX_L = 1 + AREA_W;
    localparam int MINY_L = MINX_L + C;
    localparam int MAXX_L = MINY_L + C;
    localparam int MAXY_L = MAXX_L + C;
    localparam int CNT_L  = MAXY_L + C;
    localparam int STAT_L = CNT_L + CNT_W;

    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // count stays within the store
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[STAT_L-1:CNT_L] <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // a dropped append carries no shape or test result
    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[STAT_L] == ppaq_pkg::STATUS_FULL)
        |-> m_tdata[CNT_L-1:0] == '0 && m_tdata[STAT_L-1:CNT_L] == CNT_W'(MAX_VERTICES))
        else $error("dropped append with nonzero payload or count not full");

    // bounding box is ordered
    a_box: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[MINY_L-1:MINX_L]) <= $signed(m_tdata[MAXY_L-1:MAXX_L])
                  && $signed(m_tdata[MAXX_L-1:MINY_L]) <= $signed(m_tdata[CNT_L-1:MAXY_L]))
        else $error("bounding box minimum above maximum");

endmodule

bind polygon_point_and_area_query ppaq_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
) u_ppaq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/tb_top.sv
// tb_top: self-checking bench for polygon_point_and_area_query, with directed rows and
// random polygon sequences checked against an in-bench predictor of the vertex store
// depends on ppaq_pkg and the polygon_point_and_area_query rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXV    = 64;
    localparam int COORD_W = 16;
    localparam int S_W     = 32;
    localparam int M_W     = 112;

    // result item as laid out on m_tdata, lowest bits last in the list
    typedef struct packed {
        logic                          pad;
        logic                          status;
        logic [6:0]                    count;
        logic signed [COORD_W-1:0]     max_y;
        logic signed [COORD_W-1:0]     max_x;
        logic signed [COORD_W-1:0]     min_y;
        logic signed [COORD_W-1:0]     min_x;
        logic [ppaq_pkg::AREA_W-1:0]   area;
        logic                          in_poly;
    } result_t;

    // one directed row; typed rows carry the whole expectation (all other fields zero)
    typedef struct {
        ppaq_pkg::mode_t kind;
        int    px;
        int    py;
        int    reps;
        bit    typed;
        int    want_count;
        logic  want_status;
    } stim_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;                 // px, py
    logic [1:0] s_tuser = ppaq_pkg::MODE_CLEAR;   // mode
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;            // inside_res, double_area, min_x, min_y, max_x,
                                        // max_y, vertex_count, status

    // predictor copy of the polygon
    logic signed [COORD_W-1:0] poly_x [MAXV];
    logic signed [COORD_W-1:0] poly_y [MAXV];
    int poly_n = 0;

    result_t pending_results [$];
    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    bit src_gaps_on = 1'b1;
    bit snk_stalls_on = 1'b1;

    stim_row_t directed_rows [0:24] = '{
        '{ppaq_pkg::MODE_AREA,        0,      0,  1, 1'b1,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,        0,      0,  1, 1'b1,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_APPEND, -32768, -32768,  1, 1'b1,  1, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_APPEND,  32767, -32768,  1, 1'b1,  2, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_AREA,        0,      0,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,        0, -32768,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_APPEND,  32767,  32767,  1, 1'b1,  3, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_APPEND, -32768,  32767,  1, 1'b1,  4, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_AREA,        0,      0,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,        0,      0,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,   -32768,      0,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,    32767,      0,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,        0, -32768,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,        0,  32767,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        // repeated vertex gives a zero-length edge
        '{ppaq_pkg::MODE_APPEND, -32768,  32767,  1, 1'b1,  5, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_AREA,        0,      0,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_CLEAR,       0,      0,  1, 1'b1,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,        5,      5,  1, 1'b1,  0, ppaq_pkg::STATUS_OK},
        // fill the store, then one append too many
        '{ppaq_pkg::MODE_APPEND,    100,   -100, 64, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_APPEND,      1,      1,  1, 1'b1, 64, ppaq_pkg::STATUS_FULL},
        '{ppaq_pkg::MODE_AREA,        0,      0,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,      100,   -100,  1, 1'b0,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_CLEAR,      -1,     -1,  1, 1'b1,  0, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_APPEND,      1,      1,  1, 1'b1,  1, ppaq_pkg::STATUS_OK},
        '{ppaq_pkg::MODE_TEST,        2,      1,  1, 1'b0,  0, ppaq_pkg::STATUS_OK}
    };

    polygon_point_and_area_query #(
        .MAX_VERTICES(MAXV),
        .COORD_BITS  (COORD_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // expected result of one item; updates the predictor's polygon
    function automatic result_t predict_item(ppaq_pkg::mode_t kind,
                                             logic signed [COORD_W-1:0] qx16,
                                             logic signed [COORD_W-1:0] qy16);
        result_t r;
        longint qx, qy, xi, yi, xj, yj, dy, lhs, rhs, sum;
        bit odd;
        int j;
        r = '0;
        qx = qx16;
        qy = qy16;
        case (kind)
            ppaq_pkg::MODE_CLEAR:
                poly_n = 0;
            ppaq_pkg::MODE_APPEND:
            begin
                if (poly_n < MAXV)
                begin
                    poly_x[poly_n] = qx16;
                    poly_y[poly_n] = qy16;
                    poly_n++;
                end
                else
                    r.status = ppaq_pkg::STATUS_FULL;
            end
            ppaq_pkg::MODE_TEST:
            begin
                // even-odd crossings, half-open in y, exact compare by cross-multiplying
                odd = 1'b0;
                j = poly_n - 1;
                for (int i = 0; i < poly_n; i++)
                begin
                    xi = poly_x[i];
                    yi = poly_y[i];
                    xj = poly_x[j];
                    yj = poly_y[j];
                    if ((yi < qy && yj >= qy) || (yj < qy && yi >= qy))
                    begin
                        dy = yj - yi;
                        lhs = (qy - yi) * (xj - xi);
                        rhs = (qx - xi) * dy;
                        if (dy > 0 ? (lhs < rhs) : (rhs < lhs))
                            odd = !odd;
                    end
                    j = i;
                end
                r.in_poly = odd;
            end
            default:
            begin
                // shoelace sum, absolute value, saturate
                sum = 0;
                for (int i = 0; i < poly_n; i++)
                begin
                    j = (i + 1 == poly_n) ? 0 : i + 1;
                    sum += longint'(poly_x[i]) * longint'(poly_y[j])
                         - longint'(poly_y[i]) * longint'(poly_x[j]);
                end
                if (sum < 0)
                    sum = -sum;
                if (sum > longint'(ppaq_pkg::AREA_MAX))
                    r.area = ppaq_pkg::AREA_MAX;
                else
                    r.area = sum[ppaq_pkg::AREA_W-1:0];
                // bounding box, zero when empty
                if (poly_n > 0)
                begin
                    r.min_x = poly_x[0];
                    r.max_x = poly_x[0];
                    r.min_y = poly_y[0];
                    r.max_y = poly_y[0];
                    for (int i = 1; i < poly_n; i++)
                    begin
                        if (poly_x[i] < r.min_x) r.min_x = poly_x[i];
                        if (poly_y[i] < r.min_y) r.min_y = poly_y[i];
                        if (poly_x[i] > r.max_x) r.max_x = poly_x[i];
                        if (poly_y[i] > r.max_y) r.max_y = poly_y[i];
                    end
                end
            end
        endcase
        r.count = 7'(poly_n);
        return r;
    endfunction

    // random coordinate near a center; zero span means the full range
    function automatic logic signed [COORD_W-1:0] pick_coord(int center, int span);
        logic signed [COORD_W-1:0] v;
        if (span == 0)
            v = COORD_W'($urandom);
        else
            v = COORD_W'(center + int'($urandom_range(0, 2 * span)) - span);
        return v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result item %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
    endtask

    // drive one input item and queue its expected result once it is accepted
    task automatic send_item(ppaq_pkg::mode_t kind, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, bit typed, int want_count,
                             logic want_status);
        int gap;
        result_t want;
        gap = src_gaps_on ? $urandom_range(0, 7) : 0;
        want = predict_item(kind, x, y);
        if (typed)
        begin
            want = '0;
            want.count = 7'(want_count);
            want.status = want_status;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {y, x};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results = {pending_results, want};
        items_sent++;
    endtask

    // compare one result item with the oldest expectation
    task automatic check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result item, vertex_count", got.count, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.in_poly !== want.in_poly)
            report_mismatch("inside_res", got.in_poly, want.in_poly);
        if (got.area !== want.area) report_mismatch("double_area", got.area, want.area);
        if (got.min_x !== want.min_x) report_mismatch("min_x", got.min_x, want.min_x);
        if (got.min_y !== want.min_y) report_mismatch("min_y", got.min_y, want.min_y);
        if (got.max_x !== want.max_x) report_mismatch("max_x", got.max_x, want.max_x);
        if (got.max_y !== want.max_y) report_mismatch("max_y", got.max_y, want.max_y);
        if (got.count !== want.count) report_mismatch("vertex_count", got.count, want.count);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    endtask

    // result side: random stalls with stretches of none
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                check_result(result_t'(m_tdata));
                results_seen++;
                if ($urandom_range(0, 24) == 0)
                    snk_stalls_on = !snk_stalls_on;
                stall = snk_stalls_on ? $urandom_range(0, 7) : 0;
            end
            else if (stall > 0)
                stall--;
            m_tready <= (stall == 0);
        end
    end

    // reset, directed rows, random polygon sequences, drain
    initial
    begin
        int random_goal, span, center, n, nq, sel, vi, vj;
        logic signed [COORD_W-1:0] tx, ty;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; repeated rows step the coordinates
        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_item(directed_rows[r].kind, 16'(directed_rows[r].px + k * 997),
                          16'(directed_rows[r].py - k * 613), directed_rows[r].typed,
                          directed_rows[r].want_count, directed_rows[r].want_status);

        // random part: mostly clear, build, query sequences, some noise
        random_goal = items_sent + 1200;
        while (items_sent < random_goal)
        begin
            src_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(ppaq_pkg::mode_t'($urandom_range(0, 3)), 16'($urandom),
                          16'($urandom), 1'b0, 0, ppaq_pkg::STATUS_OK);
                continue;
            end
            case ($urandom_range(0, 3))
                0: span = 0;
                1: span = 4;
                2: span = 16;
                default: span = 1000;
            endcase
            center = int'($urandom_range(0, 60000)) - 30000;
            send_item(ppaq_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom), 1'b0, 0,
                      ppaq_pkg::STATUS_OK);

            // mostly small polygons, a few that fill the store and overflow
            sel = $urandom_range(0, 19);
            if (sel < 13)
                n = $urandom_range(0, 8);
            else if (sel < 18)
                n = $urandom_range(9, 24);
            else
                n = $urandom_range(60, 66);
            repeat (n)
                send_item(ppaq_pkg::MODE_APPEND, pick_coord(center, span),
                          pick_coord(center, span), 1'b0, 0, ppaq_pkg::STATUS_OK);

            nq = $urandom_range(2, 10);
            repeat (nq)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    send_item(ppaq_pkg::MODE_APPEND, pick_coord(center, span),
                              pick_coord(center, span), 1'b0, 0, ppaq_pkg::STATUS_OK);
                else if (sel < 3)
                    send_item(ppaq_pkg::MODE_AREA, 16'($urandom), 16'($urandom), 1'b0, 0,
                              ppaq_pkg::STATUS_OK);
                else
                begin
                    // test points: near the shape, anywhere, on vertices, on vertex lines, on edges
                    tx = pick_coord(center, span);
                    ty = pick_coord(center, span);
                    if (poly_n > 0)
                    begin
                        vi = $urandom_range(0, poly_n - 1);
                        vj = (vi + 1 == poly_n) ? 0 : vi + 1;
                        case ($urandom_range(0, 4))
                            0: ;
                            1:
                            begin
                                tx = COORD_W'($urandom);
                                ty = COORD_W'($urandom);
                            end
                            2:
                            begin
                                tx = poly_x[vi];
                                ty = poly_y[vi];
                            end
                            3:
                            begin
                                tx = poly_x[vi];
                                ty = poly_y[$urandom_range(0, poly_n - 1)];
                            end
                            default:
                            begin
                                tx = COORD_W'((int'(poly_x[vi]) + int'(poly_x[vj])) / 2);
                                ty = COORD_W'((int'(poly_y[vi]) + int'(poly_y[vj])) / 2);
                            end
                        endcase
                    end
                    send_item(ppaq_pkg::MODE_TEST, tx, ty, 1'b0, 0, ppaq_pkg::STATUS_OK);
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain, then allow for the longest walk
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
